@@ design/sst_pkg.sv @@
// Package for the stacking slot table.
// Shared types, codes and default sizes; no dependencies.
package sst_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KEY_W          = 16;
  localparam int AMT_W          = 16;
  localparam int IO_IDX_W       = 6;
  localparam int READ_W         = 16;
  localparam int CFG_W          = 7;
  localparam int CFG_RESET      = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    PH_CLEAR,
    PH_IDLE,
    PH_SCAN,
    PH_RD_A,
    PH_RD_B,
    PH_UPD,
    PH_WR_B,
    PH_DONE
  } ph_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_mode_t;

  typedef struct packed {
    logic key_match;
    logic key_empty;
    logic amt_ge;
  } alu_flags_t;

endpackage

@@ design/stacking_slot_table.sv @@
// Stacking slot table: keyed slots with stack counts, first-free allocation.
// One item at a time: an item is taken only while idle, after the result of the
// last one has been registered for output; an add looks for its key with the
// one-slot-per-cycle RAM scan over the live slots.
// Reset clears all slots by a pass over every slot; no item is taken meanwhile.
// Depends on sst_pkg, sst_ram, sst_alu.
module stacking_slot_table #(
  parameter int SLOTS      = sst_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = sst_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sst_pkg::CFG_W-1:0]     cfg_slots_in_use,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [sst_pkg::KEY_W-1:0]     in_item_key,
  input  logic [sst_pkg::AMT_W-1:0]     in_amount,
  input  logic [sst_pkg::IO_IDX_W-1:0]  in_slot_index,
  input  logic [sst_pkg::IO_IDX_W-1:0]  in_target_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic                          out_updated,
  output logic [sst_pkg::IO_IDX_W-1:0]  out_slot_used,
  output logic [sst_pkg::KEY_W-1:0]     out_read_key,
  output logic [sst_pkg::READ_W-1:0]    out_read_count
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LIVE_W = ($clog2(SLOTS + 1) > sst_pkg::CFG_W) ?
                          $clog2(SLOTS + 1) : sst_pkg::CFG_W;
  localparam int W      = sst_pkg::KEY_W + COUNT_BITS;
  localparam int IOW    = sst_pkg::IO_IDX_W;
  localparam int KW     = sst_pkg::KEY_W;
  localparam int RW     = sst_pkg::READ_W;

  sst_pkg::ph_t                ph_r, ph_nxt;
  logic [sst_pkg::CFG_W-1:0]   slots_in_use_r;
  logic [LIVE_W-1:0]           live_n;

  sst_pkg::op_t                op_r, in_op;
  logic [KW-1:0]               key_r;
  logic [sst_pkg::AMT_W-1:0]   amt_r;
  logic [IDX_W-1:0]            src_r, dst_r;

  logic [LIVE_W-1:0]           issue_r, issue_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]            chk_idx_r, chk_idx_nxt;
  logic                        efound_r, efound_nxt;
  logic [IDX_W-1:0]            eidx_r, eidx_nxt;
  logic [W-1:0]                hold_r, hold_nxt;
  logic [IDX_W-1:0]            clr_r;

  sst_pkg::stat_t              res_status_r, res_status_nxt;
  logic                        res_upd_r, res_upd_nxt;
  logic [IOW-1:0]              res_used_r, res_used_nxt;
  logic [KW-1:0]               res_rkey_r, res_rkey_nxt;
  logic [RW-1:0]               res_rcnt_r, res_rcnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  sst_pkg::stat_t              out_status_r;
  logic                        out_updated_r;
  logic [IOW-1:0]              out_slot_used_r;
  logic [KW-1:0]               out_read_key_r;
  logic [RW-1:0]               out_read_count_r;

  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  logic [W-1:0]                ram_wdata, ram_rdata;
  logic [KW-1:0]               rd_key;
  logic [COUNT_BITS-1:0]       rd_cnt;

  sst_pkg::alu_mode_t          alu_mode;
  logic [COUNT_BITS-1:0]       alu_cnt, alu_res;
  sst_pkg::alu_flags_t         alu_flags;

  logic accept, arg_ok, src_ok, dst_ok;
  logic issue_more, scan_hit, scan_end, clr_last, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (ph_r != sst_pkg::PH_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_op     = sst_pkg::op_t'(in_operation);

  assign live_n = (LIVE_W'(slots_in_use_r) > LIVE_W'(SLOTS)) ?
                  LIVE_W'(SLOTS) : LIVE_W'(slots_in_use_r);

  assign src_ok = LIVE_W'(in_slot_index) < live_n;
  assign dst_ok = LIVE_W'(in_target_index) < live_n;

  always_comb begin
    case (in_op)
      sst_pkg::OP_ADD:    arg_ok = (in_item_key != '0) && (in_amount != '0);
      sst_pkg::OP_REMOVE: arg_ok = src_ok && (in_amount != '0);
      sst_pkg::OP_MOVE:   arg_ok = src_ok && dst_ok && (in_slot_index != in_target_index);
      sst_pkg::OP_READ:   arg_ok = src_ok;
      default:            arg_ok = 1'b0;
    endcase
  end

  assign rd_key     = ram_rdata[W-1 -: KW];
  assign rd_cnt     = ram_rdata[COUNT_BITS-1:0];
  assign issue_more = issue_r < live_n;
  assign scan_hit   = chk_vld_r && alu_flags.key_match;
  assign scan_end   = !chk_vld_r && !issue_more;
  assign clr_last   = (clr_r == IDX_W'(SLOTS - 1));
  assign out_free   = !out_valid_r || !out_stall;

  sst_ram #(
    .WIDTH (W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sst_alu #(
    .CNT_W (COUNT_BITS)
  ) u_alu (
    .mode   (alu_mode),
    .key_a  (rd_key),
    .key_b  (key_r),
    .cnt_a  (alu_cnt),
    .amt_b  (amt_r),
    .result (alu_res),
    .flags  (alu_flags)
  );

  // next state
  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      sst_pkg::PH_CLEAR: if (clr_last) ph_nxt = sst_pkg::PH_IDLE;
      sst_pkg::PH_IDLE: begin
        if (accept) begin
          if (!arg_ok) ph_nxt = sst_pkg::PH_DONE;
          else if (in_op == sst_pkg::OP_ADD) ph_nxt = sst_pkg::PH_SCAN;
          else ph_nxt = sst_pkg::PH_RD_A;
        end
      end
      sst_pkg::PH_SCAN: if (scan_hit || scan_end) ph_nxt = sst_pkg::PH_DONE;
      sst_pkg::PH_RD_A: begin
        ph_nxt = (op_r == sst_pkg::OP_MOVE) ? sst_pkg::PH_RD_B : sst_pkg::PH_UPD;
      end
      sst_pkg::PH_RD_B: ph_nxt = sst_pkg::PH_UPD;
      sst_pkg::PH_UPD: begin
        ph_nxt = (op_r == sst_pkg::OP_MOVE) ? sst_pkg::PH_WR_B : sst_pkg::PH_DONE;
      end
      sst_pkg::PH_WR_B: ph_nxt = sst_pkg::PH_DONE;
      sst_pkg::PH_DONE: if (out_free) ph_nxt = sst_pkg::PH_IDLE;
      default: ph_nxt = sst_pkg::PH_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = src_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = src_r;
    alu_mode       = sst_pkg::ALU_ADD;
    alu_cnt        = rd_cnt;
    issue_nxt      = issue_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    efound_nxt     = efound_r;
    eidx_nxt       = eidx_r;
    hold_nxt       = hold_r;
    res_status_nxt = res_status_r;
    res_upd_nxt    = res_upd_r;
    res_used_nxt   = res_used_r;
    res_rkey_nxt   = res_rkey_r;
    res_rcnt_nxt   = res_rcnt_r;
    case (ph_r)
      sst_pkg::PH_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      sst_pkg::PH_IDLE: begin
        issue_nxt    = '0;
        chk_vld_nxt  = 1'b0;
        efound_nxt   = 1'b0;
        res_upd_nxt  = 1'b0;
        res_used_nxt = '0;
        res_rkey_nxt = '0;
        res_rcnt_nxt = '0;
        res_status_nxt = sst_pkg::STAT_REJECT;
      end
      sst_pkg::PH_SCAN: begin
        ram_re      = issue_more;
        ram_raddr   = issue_r[IDX_W-1:0];
        issue_nxt   = issue_more ? issue_r + 1'b1 : issue_r;
        chk_vld_nxt = issue_more;
        chk_idx_nxt = issue_r[IDX_W-1:0];
        alu_cnt     = chk_vld_r ? rd_cnt : '0;
        if (chk_vld_r && alu_flags.key_empty && !efound_r) begin
          efound_nxt = 1'b1;
          eidx_nxt   = chk_idx_r;
        end
        if (scan_hit) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_idx_r;
          ram_wdata      = {key_r, alu_res};
          res_status_nxt = sst_pkg::STAT_DONE;
          res_upd_nxt    = 1'b1;
          res_used_nxt   = IOW'(chk_idx_r);
        end else if (scan_end) begin
          if (efound_r) begin
            ram_we         = 1'b1;
            ram_waddr      = eidx_r;
            ram_wdata      = {key_r, alu_res};
            res_status_nxt = sst_pkg::STAT_DONE;
            res_upd_nxt    = 1'b1;
            res_used_nxt   = IOW'(eidx_r);
          end else begin
            res_status_nxt = sst_pkg::STAT_FULL;
          end
        end
      end
      sst_pkg::PH_RD_A: begin
        ram_re = 1'b1;
      end
      sst_pkg::PH_RD_B: begin
        ram_re    = 1'b1;
        ram_raddr = dst_r;
        hold_nxt  = ram_rdata;
      end
      sst_pkg::PH_UPD: begin
        alu_mode       = sst_pkg::ALU_SUB;
        res_status_nxt = sst_pkg::STAT_DONE;
        res_used_nxt   = IOW'(src_r);
        case (op_r)
          sst_pkg::OP_REMOVE: begin
            ram_we      = 1'b1;
            ram_wdata   = alu_flags.amt_ge ? '0 : {rd_key, alu_res};
            res_upd_nxt = 1'b1;
          end
          sst_pkg::OP_MOVE: begin
            ram_we      = 1'b1;
            ram_wdata   = ram_rdata;
            res_upd_nxt = 1'b1;
          end
          sst_pkg::OP_READ: begin
            res_rkey_nxt = rd_key;
            res_rcnt_nxt = RW'(rd_cnt);
          end
          default: res_upd_nxt = 1'b0;
        endcase
      end
      sst_pkg::PH_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = hold_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ph_r == sst_pkg::PH_DONE && out_free) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r           <= sst_pkg::PH_CLEAR;
      clr_r          <= '0;
      slots_in_use_r <= sst_pkg::CFG_W'(sst_pkg::CFG_RESET);
      out_valid_r    <= 1'b0;
      chk_vld_r      <= 1'b0;
      efound_r       <= 1'b0;
      issue_r        <= '0;
    end else begin
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      efound_r    <= efound_nxt;
      issue_r     <= issue_nxt;
      if (ph_r == sst_pkg::PH_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) slots_in_use_r <= cfg_slots_in_use;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    eidx_r       <= eidx_nxt;
    hold_r       <= hold_nxt;
    res_status_r <= res_status_nxt;
    res_upd_r    <= res_upd_nxt;
    res_used_r   <= res_used_nxt;
    res_rkey_r   <= res_rkey_nxt;
    res_rcnt_r   <= res_rcnt_nxt;
    if (accept) begin
      op_r  <= in_op;
      key_r <= in_item_key;
      amt_r <= in_amount;
      src_r <= IDX_W'(in_slot_index);
      dst_r <= IDX_W'(in_target_index);
    end
    if (ph_r == sst_pkg::PH_DONE && out_free) begin
      out_status_r     <= res_status_r;
      out_updated_r    <= res_upd_r;
      out_slot_used_r  <= res_used_r;
      out_read_key_r   <= res_rkey_r;
      out_read_count_r <= res_rcnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_updated    = out_updated_r;
  assign out_slot_used  = out_slot_used_r;
  assign out_read_key   = out_read_key_r;
  assign out_read_count = out_read_count_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ph_r != sst_pkg::PH_IDLE)
    else $error("accepted item did not start work");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == sst_pkg::PH_IDLE || ph_r == sst_pkg::PH_DONE) |-> !ram_we)
    else $error("table written while no item in work");

  a_scan_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == sst_pkg::PH_SCAN && ram_we) |-> LIVE_W'(ram_waddr) < live_n)
    else $error("add wrote a slot beyond the live count");

  a_fail_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != sst_pkg::STAT_DONE) |->
      (!out_updated_r && out_slot_used_r == '0))
    else $error("failed item reports an update");

endmodule

@@ design/sst_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/sst_alu.sv @@
// Shared compare / saturating add / subtract unit of the slot table.
// Depends on sst_pkg.
module sst_alu #(
  parameter int CNT_W = sst_pkg::COUNT_BITS_DEF
) (
  input  sst_pkg::alu_mode_t             mode,
  input  logic [sst_pkg::KEY_W-1:0]      key_a,
  input  logic [sst_pkg::KEY_W-1:0]      key_b,
  input  logic [CNT_W-1:0]               cnt_a,
  input  logic [sst_pkg::AMT_W-1:0]      amt_b,
  output logic [CNT_W-1:0]               result,
  output sst_pkg::alu_flags_t            flags
);

  localparam int SUM_W = ((CNT_W > sst_pkg::AMT_W) ? CNT_W : sst_pkg::AMT_W) + 1;
  localparam logic [CNT_W-1:0] CMAX = {CNT_W{1'b1}};

  logic [SUM_W-1:0] sum;
  logic             ge;

  assign sum = SUM_W'(cnt_a) + SUM_W'(amt_b);
  assign ge  = SUM_W'(amt_b) >= SUM_W'(cnt_a);

  always_comb begin
    flags.key_match = (key_a == key_b);
    flags.key_empty = (key_a == '0);
    flags.amt_ge    = ge;
    case (mode)
      sst_pkg::ALU_ADD: result = (sum > SUM_W'(CMAX)) ? CMAX : CNT_W'(sum);
      sst_pkg::ALU_SUB: result = cnt_a - CNT_W'(amt_b);
      default:          result = cnt_a;
    endcase
  end

endmodule
